>>> hdl/rbsr_pkg.sv
// ----------------------------------------------------------------------------
// rbsr_pkg
// Shared constants, operation codes and controller/datapath interface types
// for the rotating buffer with swap and read.
// ----------------------------------------------------------------------------
`default_nettype none

package rbsr_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int WORD_BITS   = 32;

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int SIZE_W = IDX_W + 1;
    localparam int CNT_W  = $clog2(IDX_W);
    localparam int OP_W   = 2;

    localparam int S_TDATA_W = ((2 * IDX_W + WORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((WORD_BITS + 7) / 8) * 8;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_ENTRIES);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_SWAP   = 2'd1,
        OP_ROTATE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef struct packed {
        logic cap;
        logic red_step;
        logic map;
        logic mem_wr_load;
        logic mem_rd;
        logic swap_wr_a;
        logic swap_wr_b;
        logic rotate;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_reduce;
        logic red_last;
        t_op  op;
        logic err;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

>>> hdl/rbsr_ctrl.sv
// ----------------------------------------------------------------------------
// rbsr_ctrl
// Controller state machine that sequences offset reduction, slot mapping,
// memory accesses and result hand-off for one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsr_ctrl
    import rbsr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_axis_tvalid,
    output logic      o_s_axis_tready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_REDUCE  = 8'b0000_0010,
        ST_MAP     = 8'b0000_0100,
        ST_EXEC    = 8'b0000_1000,
        ST_RD_WAIT = 8'b0001_0000,
        ST_SWAP_A  = 8'b0010_0000,
        ST_SWAP_B  = 8'b0100_0000,
        ST_FINISH  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = i_sts.need_reduce ? ST_REDUCE : ST_MAP;
                end
            end
            ST_REDUCE: begin
                o_cmd.red_step = 1'b1;
                if (i_sts.red_last) begin
                    n_state = ST_MAP;
                end
            end
            ST_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = ST_EXEC;
            end
            ST_EXEC: begin
                if (i_sts.err) begin
                    n_state = ST_FINISH;
                end else begin
                    unique case (i_sts.op)
                        OP_LOAD: begin
                            o_cmd.mem_wr_load = 1'b1;
                            n_state           = ST_FINISH;
                        end
                        OP_SWAP: begin
                            o_cmd.mem_rd = 1'b1;
                            n_state      = ST_SWAP_A;
                        end
                        OP_ROTATE: begin
                            o_cmd.rotate = 1'b1;
                            n_state      = ST_FINISH;
                        end
                        OP_READ: begin
                            o_cmd.mem_rd = 1'b1;
                            n_state      = ST_RD_WAIT;
                        end
                        default: begin
                            n_state = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_RD_WAIT: begin
                n_state = ST_FINISH;
            end
            ST_SWAP_A: begin
                o_cmd.swap_wr_a = 1'b1;
                n_state         = ST_SWAP_B;
            end
            ST_SWAP_B: begin
                o_cmd.swap_wr_b = 1'b1;
                n_state         = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> hdl/rbsr_dp.sv
// ----------------------------------------------------------------------------
// rbsr_dp
// Datapath: entry memory, rotation offset, ring length register, bit-serial
// offset remainder, slot mapping and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsr_dp
    import rbsr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,
    input  wire logic [OP_W-1:0]      i_s_axis_tuser,
    input  wire logic                 i_cfg_valid,
    input  wire logic [SIZE_W-1:0]    i_cfg_data,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                      o_m_axis_tuser
);

    logic [WORD_BITS-1:0] r_mem [MAX_ENTRIES];

    logic [SIZE_W-1:0]    r_size;
    logic [IDX_W-1:0]     r_off;
    logic [IDX_W-1:0]     r_off_map;
    logic                 r_off_ok;
    t_op                  r_op;
    logic [IDX_W-1:0]     r_a;
    logic [IDX_W-1:0]     r_b;
    logic [WORD_BITS-1:0] r_val;
    logic [IDX_W-1:0]     r_pa;
    logic [IDX_W-1:0]     r_pb;
    logic                 r_err;
    logic [IDX_W-1:0]     r_dvd;
    logic [IDX_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_cnt;
    logic [WORD_BITS-1:0] r_rd_a;
    logic [WORD_BITS-1:0] r_rd_b;
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_data;
    logic                 r_out_status;

    logic [SIZE_W-1:0]    ring_n;
    logic [SIZE_W-1:0]    rem_sh;
    logic [SIZE_W-1:0]    rem_sub;
    logic [IDX_W-1:0]     rem_nx;
    logic [SIZE_W-1:0]    sum_a;
    logic [SIZE_W-1:0]    sum_b;
    logic [SIZE_W-1:0]    slot_a;
    logic [SIZE_W-1:0]    slot_b;
    logic [SIZE_W-1:0]    n_m1;
    logic                 a_bad;
    logic                 b_bad;
    logic                 map_err;
    logic [IDX_W-1:0]     off_nx;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    always_comb begin
        if (r_size == '0) begin
            ring_n = SIZE_W'(1);
        end else if (r_size > SIZE_RESET) begin
            ring_n = SIZE_RESET;
        end else begin
            ring_n = r_size;
        end
    end

    assign rem_sh  = {r_rem, r_dvd[IDX_W-1]};
    assign rem_sub = rem_sh - ring_n;
    assign rem_nx  = (rem_sh >= ring_n) ? rem_sub[IDX_W-1:0] : rem_sh[IDX_W-1:0];

    assign sum_a  = {1'b0, r_a} + {1'b0, r_off_map};
    assign sum_b  = {1'b0, r_b} + {1'b0, r_off_map};
    assign slot_a = (sum_a >= ring_n) ? (sum_a - ring_n) : sum_a;
    assign slot_b = (sum_b >= ring_n) ? (sum_b - ring_n) : sum_b;
    assign a_bad  = ({1'b0, r_a} >= ring_n);
    assign b_bad  = ({1'b0, r_b} >= ring_n);

    always_comb begin
        case (r_op)
            OP_SWAP:   map_err = a_bad || b_bad;
            OP_ROTATE: map_err = 1'b0;
            default:   map_err = a_bad;
        endcase
    end

    assign n_m1   = ring_n - SIZE_W'(1);
    assign off_nx = (r_off_map == '0) ? n_m1[IDX_W-1:0] : (r_off_map - IDX_W'(1));

    // The stored offset keeps its full value until a rotate; the reduced copy
    // is what the slot mapping uses under the current ring length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= SIZE_RESET;
            r_off     <= '0;
            r_off_map <= '0;
            r_off_ok  <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                r_size   <= i_cfg_data;
                r_off_ok <= 1'b0;
            end else if (i_cmd.red_step && (r_cnt == '0)) begin
                r_off_map <= rem_nx;
                r_off_ok  <= 1'b1;
            end else if (i_cmd.rotate) begin
                r_off     <= off_nx;
                r_off_map <= off_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op  <= t_op'(i_s_axis_tuser);
            r_a   <= i_s_axis_tdata[IDX_W-1:0];
            r_b   <= i_s_axis_tdata[2*IDX_W-1:IDX_W];
            r_val <= i_s_axis_tdata[2*IDX_W+WORD_BITS-1:2*IDX_W];
            r_dvd <= r_off;
            r_rem <= '0;
            r_cnt <= CNT_W'(IDX_W - 1);
        end else if (i_cmd.red_step) begin
            r_dvd <= {r_dvd[IDX_W-2:0], 1'b0};
            r_rem <= rem_nx;
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.map) begin
            r_pa  <= slot_a[IDX_W-1:0];
            r_pb  <= slot_b[IDX_W-1:0];
            r_err <= map_err;
        end
    end

    always_comb begin
        wr_en   = i_cmd.mem_wr_load || i_cmd.swap_wr_a || i_cmd.swap_wr_b;
        wr_addr = i_cmd.swap_wr_b ? r_pb : r_pa;
        if (i_cmd.swap_wr_a) begin
            wr_data = r_rd_b;
        end else if (i_cmd.swap_wr_b) begin
            wr_data = r_rd_a;
        end else begin
            wr_data = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rd_a <= r_mem[r_pa];
            r_rd_b <= r_mem[r_pb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_err;
            r_out_data   <= ((r_op == OP_READ) && !r_err) ? r_rd_a : '0;
        end
    end

    assign o_sts.need_reduce = !r_off_ok;
    assign o_sts.red_last    = (r_cnt == '0);
    assign o_sts.op          = r_op;
    assign o_sts.err         = r_err;
    assign o_sts.out_free    = !r_out_valid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_W'(r_out_data);
    assign o_m_axis_tuser  = r_out_status;

endmodule

`default_nettype wire

>>> hdl/rotating_buffer_swap_read.sv
// ----------------------------------------------------------------------------
// rotating_buffer_swap_read
// Ring of words addressed through a rotation offset, with load, swap,
// rotate-right and read operations, one result word per input word.
// ----------------------------------------------------------------------------
// The block handles one input word at a time and always returns one result
// word for it. A read passes a wait state for the entry memory data, and a
// swap takes longest; the swap cost is set by the single write port of the
// entry memory, which takes the two exchanged words one after the other.
// After the ring length register is written, the first operation waits while
// a bit-serial remainder unit brings the stored offset below the new length.
// A new input word is accepted while a finished result still waits on the
// output. Entries must be loaded before they are read or swapped.
`default_nettype none

module rotating_buffer_swap_read
    import rbsr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // first_index, second_index, load_value, zero fill
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // operation
    input  wire logic [OP_W-1:0]      i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // read_value
    output logic [M_TDATA_W-1:0]      o_m_axis_tdata,
    // status
    output logic                      o_m_axis_tuser,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [SIZE_W-1:0]    i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    rbsr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    rbsr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("Rejected result carries nonzero data.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("Input accepted while previous word is in progress.");

    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.mem_wr_load, cmd.swap_wr_a, cmd.swap_wr_b}))
        else $error("More than one memory write issued in a cycle.");

    a_load_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_m_axis_tvalid)
        else $error("Result load did not raise output valid.");
`endif

endmodule

`default_nettype wire

>>> tb/tb_rotating_buffer_swap_read.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotating_buffer_swap_read
// Self-checking bench for the rotating buffer with load, swap, rotate and
// read. A short table of directed words covers field extremes, every
// operation, rejected indices and odd ring lengths. Random words then run
// through several ring lengths and handshake idling patterns. Every result
// word is checked: against the table where a row sets chk, else against a
// predictor of the ring contents, rotation offset and length register.
// ----------------------------------------------------------------------------

module tb_rotating_buffer_swap_read;
    import rbsr_pkg::*;

    typedef enum logic {
        ROW_ITEM,
        ROW_SIZE
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_op                   op;
        logic [IDX_W-1:0]      a;
        logic [IDX_W-1:0]      b;
        logic [WORD_BITS-1:0]  v;
        logic [SIZE_W-1:0]     size;
        logic                  chk;
        logic [WORD_BITS-1:0]  ew;
        logic                  es;
    } t_row;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 status;
    } t_ring_result;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        int                gap;
        int                stall;
        int                count;
    } t_phase;

    localparam int N_ROWS   = 27;
    localparam int N_PHASES = 10;

    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        '{ROW_ITEM, OP_LOAD,   10'd0,    10'd0,    32'hFFFF_FFFF, 11'd0,    1'b1, 32'h0, 1'b0},
        '{ROW_ITEM, OP_LOAD,   10'd1023, 10'd1023, 32'h0000_0000, 11'd0,    1'b1, 32'h0, 1'b0},
        '{ROW_ITEM, OP_LOAD,   10'd1,    10'd0,    32'hA5A5_A5A5, 11'd0,    1'b1, 32'h0, 1'b0},
        '{ROW_ITEM, OP_LOAD,   10'd682,  10'd341,  32'h5A5A_5A5A, 11'd0,    1'b1, 32'h0, 1'b0},
        '{ROW_ITEM, OP_READ,   10'd0,    10'd0,    32'h0,  11'd0, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{ROW_ITEM, OP_READ,   10'd1023, 10'd0,    32'h0,  11'd0, 1'b1, 32'h0000_0000, 1'b0},
        '{ROW_ITEM, OP_SWAP,   10'd0,    10'd1,    32'h0,  11'd0, 1'b1, 32'h0, 1'b0},
        '{ROW_ITEM, OP_READ,   10'd1,    10'd0,    32'h0,  11'd0, 1'b0, 32'h0, 1'b0},
        '{ROW_ITEM, OP_SWAP,   10'd1023, 10'd1023, 32'h0,  11'd0, 1'b1, 32'h0, 1'b0},
        '{ROW_ITEM, OP_ROTATE, 10'd1023, 10'd1023, 32'hFFFF_FFFF, 11'd0,    1'b1, 32'h0, 1'b0},
        '{ROW_ITEM, OP_READ,   10'd1,    10'd0,    32'h0,  11'd0, 1'b0, 32'h0, 1'b0},
        '{ROW_ITEM, OP_READ,   10'd0,    10'd0,    32'h0,  11'd0, 1'b0, 32'h0, 1'b0},
        '{ROW_ITEM, OP_SWAP,   10'd683,  10'd1,    32'h0,  11'd0, 1'b0, 32'h0, 1'b0},
        '{ROW_SIZE, OP_LOAD,   10'd0,    10'd0,    32'h0,  11'd4, 1'b0, 32'h0, 1'b0},
        '{ROW_ITEM, OP_LOAD,   10'd4,    10'd0,    32'hDEAD_BEEF, 11'd0,    1'b1, 32'h0, 1'b1},
        '{ROW_ITEM, OP_SWAP,   10'd0,    10'd5,    32'h0,  11'd0, 1'b1, 32'h0, 1'b1},
        '{ROW_ITEM, OP_SWAP,   10'd1023, 10'd0,    32'h0,  11'd0, 1'b1, 32'h0, 1'b1},
        '{ROW_ITEM, OP_READ,   10'd4,    10'd0,    32'h0,  11'd0, 1'b1, 32'h0, 1'b1},
        '{ROW_ITEM, OP_ROTATE, 10'd0,    10'd0,    32'h0,  11'd0, 1'b1, 32'h0, 1'b0},
        '{ROW_ITEM, OP_READ,   10'd2,    10'd0,    32'h0,  11'd0, 1'b0, 32'h0, 1'b0},
        '{ROW_ITEM, OP_LOAD,   10'd3,    10'd0,    32'h1234_5678, 11'd0,    1'b1, 32'h0, 1'b0},
        '{ROW_SIZE, OP_LOAD,   10'd0,    10'd0,    32'h0,  11'd0, 1'b0, 32'h0, 1'b0},
        '{ROW_ITEM, OP_LOAD,   10'd1,    10'd0,    32'h0,  11'd0, 1'b1, 32'h0, 1'b1},
        '{ROW_ITEM, OP_ROTATE, 10'd0,    10'd0,    32'h0,  11'd0, 1'b1, 32'h0, 1'b0},
        '{ROW_ITEM, OP_READ,   10'd0,    10'd0,    32'h0,  11'd0, 1'b0, 32'h0, 1'b0},
        '{ROW_SIZE, OP_LOAD,   10'd0,    10'd0,    32'h0,  11'd2047, 1'b0, 32'h0, 1'b0},
        '{ROW_ITEM, OP_READ,   10'd1023, 10'd0,    32'h0,  11'd0, 1'b0, 32'h0, 1'b0}
    };

    localparam t_phase PHASES [N_PHASES] = '{
        '{11'd1024, 0,  0,  300},
        '{11'd16,   64, 0,  250},
        '{11'd1,    0,  64, 120},
        '{11'd2047, 31, 31, 300},
        '{11'd37,   0,  0,  200},
        '{11'd1000, 64, 0,  250},
        '{11'd3,    31, 31, 150},
        '{11'd0,    0,  0,  80},
        '{11'd512,  0,  64, 200},
        '{11'd2,    31, 31, 100}
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_valid   = 1'b0;
    logic [S_TDATA_W-1:0]  s_data    = '0;
    logic [OP_W-1:0]       s_user    = '0;
    logic                  m_ready   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [SIZE_W-1:0]     cfg_data  = '0;

    wire                   s_ready;
    wire                   m_valid;
    wire [M_TDATA_W-1:0]   m_data;
    wire                   m_user;
    wire                   cfg_ready;

    logic [WORD_BITS-1:0]  ring_words [MAX_ENTRIES];
    bit                    slot_loaded [MAX_ENTRIES];
    logic [SIZE_W-1:0]     ring_size_reg;
    int unsigned           rot_offset;

    t_ring_result          pending_results [$];
    int                    mismatch_count = 0;
    int                    gap_pct        = 0;
    int                    stall_pct      = 0;

    always #1 clk = ~clk;

    rotating_buffer_swap_read dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    function automatic int unsigned ring_len();
        if (ring_size_reg == 0) begin
            return 1;
        end
        if (ring_size_reg > MAX_ENTRIES) begin
            return MAX_ENTRIES;
        end
        return ring_size_reg;
    endfunction

    function automatic int unsigned slot_of(int unsigned idx, int unsigned n);
        return (idx + rot_offset % n) % n;
    endfunction

    function automatic t_ring_result apply_ring_op(t_op op, logic [IDX_W-1:0] a,
                                                   logic [IDX_W-1:0] b,
                                                   logic [WORD_BITS-1:0] v);
        t_ring_result         res;
        int unsigned          n;
        int unsigned          pa;
        int unsigned          pb;
        int unsigned          off;
        logic [WORD_BITS-1:0] tmp;
        n          = ring_len();
        pa         = slot_of(a, n);
        pb         = slot_of(b, n);
        res.word   = '0;
        res.status = 1'b0;
        case (op)
            OP_LOAD: begin
                if (a < n) begin
                    ring_words[pa]  = v;
                    slot_loaded[pa] = 1'b1;
                end else begin
                    res.status = 1'b1;
                end
            end
            OP_SWAP: begin
                if (a < n && b < n) begin
                    tmp            = ring_words[pa];
                    ring_words[pa] = ring_words[pb];
                    ring_words[pb] = tmp;
                end else begin
                    res.status = 1'b1;
                end
            end
            OP_ROTATE: begin
                off        = rot_offset % n;
                rot_offset = (off == 0) ? n - 1 : off - 1;
            end
            default: begin
                if (a < n) begin
                    res.word = ring_words[pa];
                end else begin
                    res.status = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(int unsigned n);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) begin
            return IDX_W'($urandom);
        end
        if (r < 55) begin
            return IDX_W'($urandom_range(((n < 32) ? n : 32) - 1));
        end
        return IDX_W'($urandom_range(n - 1));
    endfunction

    task automatic send_word(t_op op, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                             logic [WORD_BITS-1:0] v, logic chk,
                             logic [WORD_BITS-1:0] ew, logic es);
        t_ring_result res;
        @(negedge clk);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= S_TDATA_W'({v, b, a});
        s_user  <= op;
        @(posedge clk);
        while (!s_ready) begin
            @(posedge clk);
        end
        res = apply_ring_op(op, a, b, v);
        if (chk) begin
            res.word   = ew;
            res.status = es;
        end
        pending_results.push_back(res);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] value);
        @(negedge clk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        ring_size_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin : result_check
        t_ring_result oldest;
        if (rst_n && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word with none pending, data %h status %b",
                         $time, m_data, m_user);
                mismatch_count++;
            end else begin
                oldest = pending_results.pop_front();
                if (m_data !== M_TDATA_W'(oldest.word)) begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, oldest.word, m_data);
                    mismatch_count++;
                end
                if (m_user !== oldest.status) begin
                    $display("%0t: status expected %b actual %b",
                             $time, oldest.status, m_user);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_row                 row;
        t_op                  op;
        logic [IDX_W-1:0]     a;
        logic [IDX_W-1:0]     b;
        logic [WORD_BITS-1:0] v;
        int unsigned          n;
        int unsigned          r;
        ring_size_reg = SIZE_RESET;
        rot_offset    = 0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            slot_loaded[i] = 1'b0;
            ring_words[i]  = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_SIZE) begin
                write_size(row.size);
            end else begin
                send_word(row.op, row.a, row.b, row.v, row.chk, row.ew, row.es);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_size(PHASES[p].size);
            gap_pct   = PHASES[p].gap;
            stall_pct = PHASES[p].stall;
            for (int k = 0; k < PHASES[p].count; k++) begin
                n = ring_len();
                r = $urandom_range(99);
                op = (r < 30) ? OP_LOAD : (r < 55) ? OP_SWAP : (r < 70) ? OP_ROTATE : OP_READ;
                a = pick_index(n);
                b = pick_index(n);
                v = $urandom;
                // Entries that were never loaded are neither read nor swapped.
                if (op == OP_READ && a < n && !slot_loaded[slot_of(a, n)]) begin
                    op = OP_LOAD;
                end
                if (op == OP_SWAP && a < n && b < n) begin
                    if (!slot_loaded[slot_of(a, n)]) begin
                        op = OP_LOAD;
                    end else if (!slot_loaded[slot_of(b, n)]) begin
                        op = OP_LOAD;
                        a  = b;
                    end
                end
                send_word(op, a, b, v, 1'b0, '0, 1'b0);
            end
        end

        @(negedge clk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("rotating_buffer_swap_read test passed");
        end else begin
            $display("rotating_buffer_swap_read test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("rotating_buffer_swap_read test failed");
        $finish;
    end

endmodule
